@@ rtl/wpcm_pkg.sv @@
`default_nettype none
package wpcm_pkg;

    localparam int MAX_SAMPLES = 200;
    localparam int SLOT_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

    localparam int TIME_W  = 48;
    localparam int COUNT_W = 32;
    localparam int PCT_W   = 40;
    localparam int WIN_W   = 6;
    localparam int WMS_W   = 22;   // holds WIN_MAX minutes in ms

    localparam int MS_PER_MINUTE      = 60000;
    localparam int SAMPLE_INTERVAL_MS = 30000;
    localparam int MIN_SPAN_MS        = 60000;
    localparam int HALF_MINUTE_MS     = 30000;
    localparam int PCT_Q8_SCALE       = 25600;

    localparam logic [WIN_W-1:0] WIN_MIN   = 6'd1;
    localparam logic [WIN_W-1:0] WIN_MAX   = 6'd60;
    localparam logic [WIN_W-1:0] WIN_RESET = 6'd10;

    // divider sizes: |delta| * 25600 + old/2 fits 48 bits
    localparam int DIVD_W = 48;
    localparam int DIVR_W = 32;
    localparam int DCNT_W = $clog2(DIVD_W);

    // floor(x / 60000) == (x * MIN_RECIP) >> RECIP_SHIFT for x < 2^22
    localparam int                RECIP_W     = 23;
    localparam logic [RECIP_W-1:0] MIN_RECIP  = 23'd4581299;
    localparam int                RECIP_SHIFT = 38;
    localparam int                MPROD_W     = WMS_W + RECIP_W;

    typedef struct packed {
        logic [TIME_W-1:0]  time_ms;
        logic [COUNT_W-1:0] count_now;
    } t_in_item;

    typedef struct packed {
        logic                     delta_valid;
        logic signed [PCT_W-1:0]  percent_q8;
        logic [WIN_W-1:0]         span_minutes;
    } t_out_item;

    typedef struct packed {
        logic [TIME_W-1:0]  time_ms;
        logic [COUNT_W-1:0] count_now;
    } t_sample;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRUNE_RD,
        S_PRUNE_CHK,
        S_LAST_RD,
        S_LAST_CHK,
        S_APPEND,
        S_OLD_RD,
        S_OLD_CHK,
        S_SCALE,
        S_DIV,
        S_DONE
    } t_state;

    // (base + off) mod MAX_SAMPLES, base < MAX_SAMPLES, off <= MAX_SAMPLES
    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                   input logic [CNT_W-1:0]  off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(MAX_SAMPLES)) begin
            sum = sum - (CNT_W+1)'(MAX_SAMPLES);
        end
        return sum[SLOT_W-1:0];
    endfunction

endpackage
`default_nettype wire

@@ rtl/windowed_percent_change_monitor.sv @@
`default_nettype none
// channel | direction | handshake              | payload
// in      | input     | i_in_valid / o_in_stall   | i_in_data  (t_in_item)
// out     | output    | o_out_valid / i_out_stall | o_out_data (t_out_item)
// cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_data (window_minutes)
//
// One item at a time: prune P samples (P = samples pruned), read the last sample,
// append, read the oldest, then for a percent change run a bit-serial 48-bit divider.
// Sample memory is a single-port-per-cycle array: one read or write a cycle.
// Synchronous active-low reset clears control state and sets the window to 10.
// A result waits in the output register under stall; the next item is taken
// meanwhile, and its result waits for the register to free up.
module windowed_percent_change_monitor
    import wpcm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire t_in_item         i_in_data,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_out_item             o_out_data,
    input  wire logic             i_out_stall,
    input  wire logic             i_cfg_valid,
    input  wire logic [WIN_W-1:0] i_cfg_data,
    output logic                  o_cfg_ready
);

    t_state r_state, n_state;

    logic [WIN_W-1:0]   r_window;
    logic [SLOT_W-1:0]  r_oldest, n_oldest;
    logic [CNT_W-1:0]   r_stored, n_stored;
    logic [TIME_W-1:0]  r_now, n_now;
    logic [COUNT_W-1:0] r_cur, n_cur;
    logic [WMS_W-1:0]   r_win_ms, n_win_ms;
    logic               r_add, n_add;
    logic               r_ok, n_ok;
    logic               r_neg, n_neg;
    logic [COUNT_W-1:0] r_mag, n_mag;
    logic [COUNT_W-1:0] r_old, n_old;
    logic [WMS_W-1:0]   r_xc, n_xc;
    logic [WIN_W-1:0]   r_mins, n_mins;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    t_sample            r_mem [MAX_SAMPLES];
    t_sample            r_rd;
    logic               rd_en, wr_en;
    logic [SLOT_W-1:0]  rd_addr, wr_addr;

    logic               in_acc, out_ld, cfg_wr;
    logic [WIN_W-1:0]   win_cl;
    logic [TIME_W:0]    age;
    logic               age_neg, prune_hit, last_add, old_ok, full;
    logic [WMS_W-1:0]   win_lo;
    logic [MPROD_W-1:0] mins_prod;
    logic [DIVD_W-1:0]  dividend;
    logic               div_start, div_done;
    logic [DIVD_W-1:0]  quotient;
    logic [PCT_W-1:0]   pct;

    assign in_acc = i_in_valid && !o_in_stall;
    assign out_ld = !r_out_valid || !i_out_stall;
    assign cfg_wr = i_cfg_valid && o_cfg_ready;

    assign win_cl = (r_window < WIN_MIN) ? WIN_MIN :
                    (r_window > WIN_MAX) ? WIN_MAX : r_window;

    // shared age subtractor: current time against the sample just read
    assign age       = {1'b0, r_now} - {1'b0, r_rd.time_ms};
    assign age_neg   = age[TIME_W];
    assign prune_hit = !age_neg && (age[TIME_W-1:0] > TIME_W'(r_win_ms));
    assign last_add  = (r_rd.count_now != r_cur) ||
                       (!age_neg && (age[TIME_W-1:0] >= TIME_W'(SAMPLE_INTERVAL_MS)));
    assign old_ok    = (r_stored >= CNT_W'(2)) && !age_neg &&
                       (age[TIME_W-1:0] >= TIME_W'(MIN_SPAN_MS)) &&
                       (r_rd.count_now != '0);
    assign full      = (r_stored == CNT_W'(MAX_SAMPLES));
    assign win_lo    = r_win_ms - WMS_W'(HALF_MINUTE_MS);

    assign mins_prod = MPROD_W'(r_xc) * MPROD_W'(MIN_RECIP);
    assign dividend  = DIVD_W'(r_mag) * DIVD_W'(PCT_Q8_SCALE) +
                       DIVD_W'(r_old[COUNT_W-1:1]);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_in_valid) n_state = S_PRUNE_RD;
            S_PRUNE_RD:  n_state = (r_stored == '0) ? S_LAST_RD : S_PRUNE_CHK;
            S_PRUNE_CHK: n_state = prune_hit ? S_PRUNE_RD : S_LAST_RD;
            S_LAST_RD:   n_state = (r_stored == '0) ? S_APPEND : S_LAST_CHK;
            S_LAST_CHK:  n_state = S_APPEND;
            S_APPEND:    n_state = S_OLD_RD;
            S_OLD_RD:    n_state = (r_stored >= CNT_W'(2)) ? S_OLD_CHK : S_DONE;
            S_OLD_CHK:   n_state = S_SCALE;
            S_SCALE:     n_state = r_ok ? S_DIV : S_DONE;
            S_DIV:       if (div_done) n_state = S_DONE;
            S_DONE:      if (out_ld) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // memory and divider control
    always_comb begin
        rd_en     = 1'b0;
        rd_addr   = r_oldest;
        wr_en     = 1'b0;
        wr_addr   = full ? r_oldest : slot_add(r_oldest, r_stored);
        div_start = 1'b0;
        unique case (r_state)
            S_PRUNE_RD: rd_en = 1'b1;
            S_LAST_RD: begin
                rd_en   = (r_stored != '0);
                rd_addr = slot_add(r_oldest, r_stored - 1'b1);
            end
            S_APPEND:   wr_en = r_add;
            S_OLD_RD:   rd_en = 1'b1;
            S_SCALE:    div_start = r_ok;
            default: begin
            end
        endcase
    end

    // datapath
    always_comb begin
        n_oldest    = r_oldest;
        n_stored    = r_stored;
        n_now       = r_now;
        n_cur       = r_cur;
        n_win_ms    = r_win_ms;
        n_add       = r_add;
        n_ok        = r_ok;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_old       = r_old;
        n_xc        = r_xc;
        n_mins      = r_mins;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        pct         = '0;
        if (r_neg) begin
            pct = -quotient[PCT_W-1:0];
        end else if (quotient[DIVD_W-1:PCT_W-1] != '0) begin
            pct = {1'b0, {(PCT_W-1){1'b1}}};
        end else begin
            pct = quotient[PCT_W-1:0];
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_now    = i_in_data.time_ms;
                    n_cur    = i_in_data.count_now;
                    n_win_ms = WMS_W'(win_cl) * WMS_W'(MS_PER_MINUTE);
                end
            end
            S_PRUNE_CHK: begin
                if (prune_hit) begin
                    n_oldest = slot_add(r_oldest, CNT_W'(1));
                    n_stored = r_stored - 1'b1;
                end
            end
            S_LAST_RD:  n_add = 1'b1;
            S_LAST_CHK: n_add = last_add;
            S_APPEND: begin
                if (r_add) begin
                    if (full) begin
                        n_oldest = slot_add(r_oldest, CNT_W'(1));
                    end else begin
                        n_stored = r_stored + 1'b1;
                    end
                end
            end
            S_OLD_RD: n_ok = 1'b0;
            S_OLD_CHK: begin
                n_ok  = old_ok;
                n_neg = r_cur < r_rd.count_now;
                n_mag = n_neg ? (r_rd.count_now - r_cur) : (r_cur - r_rd.count_now);
                n_old = r_rd.count_now;
                // span clamped to the window before the rounded divide by a minute
                n_xc  = (age[TIME_W-1:0] >= TIME_W'(win_lo)) ? r_win_ms :
                        (age[WMS_W-1:0] + WMS_W'(HALF_MINUTE_MS));
            end
            S_SCALE: n_mins = mins_prod[RECIP_SHIFT +: WIN_W];
            S_DONE: begin
                if (out_ld) begin
                    n_out_valid        = 1'b1;
                    n_out.delta_valid  = r_ok;
                    n_out.percent_q8   = r_ok ? pct : '0;
                    n_out.span_minutes = r_ok ? r_mins : '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_window    <= WIN_RESET;
            r_oldest    <= '0;
            r_stored    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_oldest    <= n_oldest;
            r_stored    <= n_stored;
            r_out_valid <= n_out_valid;
            if (cfg_wr) begin
                r_window <= i_cfg_data;
            end
        end
        r_now    <= n_now;
        r_cur    <= n_cur;
        r_win_ms <= n_win_ms;
        r_add    <= n_add;
        r_ok     <= n_ok;
        r_neg    <= n_neg;
        r_mag    <= n_mag;
        r_old    <= n_old;
        r_xc     <= n_xc;
        r_mins   <= n_mins;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= '{time_ms: r_now, count_now: r_cur};
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    wpcm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (r_old),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

@@ rtl/wpcm_div.sv @@
`default_nettype none
module wpcm_div
    import wpcm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIVD_W-1:0] i_dividend,
    input  wire logic [DIVR_W-1:0] i_divisor,
    output logic                   o_done,
    output logic [DIVD_W-1:0]      o_quotient
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [DCNT_W-1:0] r_cnt, n_cnt;
    logic [DIVR_W-1:0] r_rem, n_rem;
    logic [DIVD_W-1:0] r_quo, n_quo;
    logic [DIVR_W-1:0] r_dvs, n_dvs;

    logic [DIVR_W:0]   rem_sh;
    logic [DIVR_W+1:0] diff;
    logic              ge;

    // restoring division, one quotient bit per cycle
    always_comb begin
        rem_sh = {r_rem, r_quo[DIVD_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, r_dvs};
        ge     = !diff[DIVR_W+1];

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem = ge ? diff[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
            n_quo = {r_quo[DIVD_W-2:0], ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DCNT_W'(DIVD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire
